>>> src/assert_macros.svh
// assertion helpers shared by the rtl; each expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DQU_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DQU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dqu_pkg.sv
`default_nettype none

package dqu_pkg;

  // default capacity in words
  localparam int DEPTH_DEF = 16;

  // payload field widths
  localparam int WORD_W = 32;
  localparam int ACT_W  = 3;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_UPDATE     = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

  // word returned by a pop on an empty queue
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  // per-cell storage operation
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_BACK,
    CELL_SHIFT_FRONT,
    CELL_WRITE
  } dqu_word_op_t;

  // per-cell collect-chain operation
  typedef enum logic [1:0] {
    COL_HOLD,
    COL_LOAD,
    COL_SHIFT
  } dqu_col_op_t;

  // control broadcast to every cell
  typedef struct packed {
    dqu_word_op_t               word_op;
    dqu_col_op_t                col_op;
    logic signed [WORD_W-1:0]   data;
  } dqu_cell_ctl_t;

  // one result transaction
  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic [STAT_W-1:0]        status;
    logic                     is_empty;
  } dqu_result_t;

  // control sequencer
  typedef enum logic {
    ST_IDLE,
    ST_GATHER
  } dqu_state_t;

endpackage

`default_nettype wire

>>> src/dqu_in_if.sv
`default_nettype none

interface dqu_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [dqu_pkg::ACT_W-1:0]              action;
  logic signed [dqu_pkg::WORD_W-1:0]      value;
  logic [dqu_pkg::POS_W-1:0]              position;

  modport source (output valid, output action, output value, output position, input ready);
  modport sink   (input valid, input action, input value, input position, output ready);
endinterface

`default_nettype wire

>>> src/dqu_out_if.sv
`default_nettype none

interface dqu_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [dqu_pkg::WORD_W-1:0]      popped_value;
  logic [dqu_pkg::STAT_W-1:0]             status;
  logic                                   is_empty;

  modport source (output valid, output popped_value, output status, output is_empty,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input is_empty,
                  output ready);
endinterface

`default_nettype wire

>>> src/dqu_cell.sv
`default_nettype none

module dqu_cell #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  wire logic                                clk,
  input  wire dqu_pkg::dqu_cell_ctl_t              ctl,
  input  wire logic [IDX_W-1:0]                    wr_idx,
  input  wire logic signed [dqu_pkg::WORD_W-1:0]   left_word,
  input  wire logic signed [dqu_pkg::WORD_W-1:0]   right_word,
  input  wire logic signed [dqu_pkg::WORD_W-1:0]   right_col,
  output      logic signed [dqu_pkg::WORD_W-1:0]   word_o,
  output      logic signed [dqu_pkg::WORD_W-1:0]   col_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [dqu_pkg::WORD_W-1:0] word_r, word_nxt;
  logic signed [dqu_pkg::WORD_W-1:0] col_r, col_nxt;

  // stored word: hold, take a neighbor's word, or take the broadcast data
  always_comb begin
    unique case (ctl.word_op)
      dqu_pkg::CELL_HOLD:        word_nxt = word_r;
      dqu_pkg::CELL_SHIFT_BACK:  word_nxt = left_word;
      dqu_pkg::CELL_SHIFT_FRONT: word_nxt = right_word;
      dqu_pkg::CELL_WRITE:       word_nxt = (wr_idx == MY_IDX) ? ctl.data : word_r;
      default:                   word_nxt = word_r;
    endcase
  end

  // collect chain: snapshot own word, then pass toward the front
  always_comb begin
    unique case (ctl.col_op)
      dqu_pkg::COL_HOLD:  col_nxt = col_r;
      dqu_pkg::COL_LOAD:  col_nxt = word_r;
      dqu_pkg::COL_SHIFT: col_nxt = right_col;
      default:            col_nxt = col_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    col_r  <= col_nxt;
  end

  assign word_o = word_r;
  assign col_o  = col_r;

endmodule

`default_nettype wire

>>> src/double_ended_queue_unit.sv
`default_nettype none
`include "assert_macros.svh"

// Bounded double-ended queue of signed 32-bit words held in a row of DEPTH
// cells, the front word always in cell 0. Push front and pop front shift the
// whole row by one cell, push back and update write one cell picked by index,
// and each of these (and every pop on an empty queue, full push or
// out-of-range update) needs no gather, so such transactions are accepted
// back to back while the skid entry is empty. Pop back runs a gather: the
// tail word is carried to cell 0 along a collect chain, one cell per cycle,
// and no new transaction is accepted meanwhile. Results pass through a
// two-entry output buffer, so a stalled result does not hold up the next
// transaction. The store needs no clearing after reset.
module double_ended_queue_unit #(
  parameter int DEPTH = dqu_pkg::DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  dqu_in_if.sink        in_chan,
  dqu_out_if.source     out_chan
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > dqu_pkg::POS_W) ? CNT_W : dqu_pkg::POS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  dqu_pkg::dqu_state_t  state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     gcnt_r, gcnt_nxt;

  dqu_pkg::dqu_cell_ctl_t cell_ctl;
  logic [IDX_W-1:0]       wr_idx;
  logic signed [dqu_pkg::WORD_W-1:0] word_w [DEPTH];
  logic signed [dqu_pkg::WORD_W-1:0] col_w  [DEPTH];

  logic                 in_fire;
  logic                 is_full;
  logic                 is_zero;
  logic [CMP_W-1:0]     pos_cmp;
  logic [CMP_W-1:0]     cnt_cmp;

  logic                 res_vld;
  dqu_pkg::dqu_result_t res;

  logic                 out_vld_r, out_vld_nxt;
  dqu_pkg::dqu_result_t out_res_r, out_res_nxt;
  logic                 skid_vld_r, skid_vld_nxt;
  dqu_pkg::dqu_result_t skid_res_r, skid_res_nxt;
  logic                 head_free;

  // handshake and occupancy
  assign in_chan.ready = (state_r == dqu_pkg::ST_IDLE) && !skid_vld_r;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign is_full       = (count_r == FULL_CNT);
  assign is_zero       = (count_r == '0);
  assign pos_cmp       = CMP_W'(in_chan.position);
  assign cnt_cmp       = CMP_W'(count_r);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dqu_pkg::ST_IDLE: begin
        if (in_fire && in_chan.action == dqu_pkg::ACT_POP_BACK && !is_zero) begin
          state_nxt = dqu_pkg::ST_GATHER;
        end
      end
      dqu_pkg::ST_GATHER: begin
        if (gcnt_r == '0) begin
          state_nxt = dqu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dqu_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: cell control, counters and the result
  always_comb begin
    count_nxt        = count_r;
    gcnt_nxt         = gcnt_r;
    cell_ctl.word_op = dqu_pkg::CELL_HOLD;
    cell_ctl.col_op  = dqu_pkg::COL_HOLD;
    cell_ctl.data    = in_chan.value;
    wr_idx           = count_r[IDX_W-1:0];
    res_vld          = 1'b0;
    res.popped_value = '0;
    res.status       = dqu_pkg::STAT_OK;
    unique case (state_r)
      dqu_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_vld = 1'b1;
          unique case (in_chan.action)
            dqu_pkg::ACT_PUSH_FRONT: begin
              if (is_full) begin
                res.status = dqu_pkg::STAT_FULL;
              end else begin
                cell_ctl.word_op = dqu_pkg::CELL_SHIFT_BACK;
                count_nxt        = count_r + 1'b1;
              end
            end
            dqu_pkg::ACT_PUSH_BACK: begin
              if (is_full) begin
                res.status = dqu_pkg::STAT_FULL;
              end else begin
                cell_ctl.word_op = dqu_pkg::CELL_WRITE;
                count_nxt        = count_r + 1'b1;
              end
            end
            dqu_pkg::ACT_POP_FRONT: begin
              if (is_zero) begin
                res.popped_value = dqu_pkg::EMPTY_WORD;
                res.status       = dqu_pkg::STAT_EMPTY;
              end else begin
                res.popped_value = word_w[0];
                cell_ctl.word_op = dqu_pkg::CELL_SHIFT_FRONT;
                count_nxt        = count_r - 1'b1;
              end
            end
            dqu_pkg::ACT_POP_BACK: begin
              if (is_zero) begin
                res.popped_value = dqu_pkg::EMPTY_WORD;
                res.status       = dqu_pkg::STAT_EMPTY;
              end else begin
                // result comes out at the end of the gather
                res_vld         = 1'b0;
                cell_ctl.col_op = dqu_pkg::COL_LOAD;
                gcnt_nxt        = IDX_W'(count_r - 1'b1);
                count_nxt       = count_r - 1'b1;
              end
            end
            dqu_pkg::ACT_UPDATE: begin
              if (pos_cmp >= cnt_cmp) begin
                res.status = dqu_pkg::STAT_RANGE;
              end else begin
                cell_ctl.word_op = dqu_pkg::CELL_WRITE;
                wr_idx           = pos_cmp[IDX_W-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      dqu_pkg::ST_GATHER: begin
        if (gcnt_r == '0) begin
          res_vld          = 1'b1;
          res.popped_value = col_w[0];
        end else begin
          cell_ctl.col_op = dqu_pkg::COL_SHIFT;
          gcnt_nxt        = gcnt_r - 1'b1;
        end
      end
      default: ;
    endcase
    res.is_empty = (count_nxt == '0);
  end

  // row of cells, front at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [dqu_pkg::WORD_W-1:0] left_w;
    logic signed [dqu_pkg::WORD_W-1:0] right_w;
    logic signed [dqu_pkg::WORD_W-1:0] rcol_w;

    if (i == 0) begin : g_first
      assign left_w = cell_ctl.data;
    end else begin : g_inner_l
      assign left_w = word_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
      assign rcol_w  = '0;
    end else begin : g_inner_r
      assign right_w = word_w[i+1];
      assign rcol_w  = col_w[i+1];
    end

    dqu_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .wr_idx     (wr_idx),
      .left_word  (left_w),
      .right_word (right_w),
      .right_col  (rcol_w),
      .word_o     (word_w[i]),
      .col_o      (col_w[i])
    );
  end

  // two-entry output buffer: head register plus skid entry
  assign head_free = !out_vld_r || out_chan.ready;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (head_free) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = res_vld;
        skid_res_nxt = res;
      end else begin
        out_vld_nxt = res_vld;
        out_res_nxt = res;
      end
    end else if (res_vld) begin
      skid_vld_nxt = 1'b1;
      skid_res_nxt = res;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dqu_pkg::ST_IDLE;
      count_r    <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    gcnt_r     <= gcnt_nxt;
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.popped_value = out_res_r.popped_value;
  assign out_chan.status       = out_res_r.status;
  assign out_chan.is_empty     = out_res_r.is_empty;

  // checks
  `DQU_ASSERT_HOLDS(a_skid_behind_head, skid_vld_r, out_vld_r, "skid entry valid with empty head")
  `DQU_ASSERT_HOLDS(a_count_bounded, 1'b1, count_r <= FULL_CNT, "word count above capacity")
  `DQU_ASSERT_NEXT(a_push_grows, in_fire && !is_full && (in_chan.action == dqu_pkg::ACT_PUSH_FRONT || in_chan.action == dqu_pkg::ACT_PUSH_BACK), count_r == $past(count_r) + 1'b1, "accepted push did not grow the queue")
  `DQU_ASSERT_NEXT(a_gather_delivers, state_r == dqu_pkg::ST_GATHER && gcnt_r == '0, state_r == dqu_pkg::ST_IDLE && out_vld_r, "pop back gather ended without a result")

endmodule

`default_nettype wire
